[rtl/assert_macros.svh]
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define SDT_ASSERT_ON(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define SDT_ASSERT_ALL(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/sdt_pkg.sv]
`default_nettype none

package sdt_pkg;

  localparam int MAX_DELIM_DEF = 8;
  localparam int POS_BITS_DEF  = 16;

  localparam int CHAR_W    = 8;
  localparam int OUT_W     = 16;
  localparam int DELIM_W   = 64;
  localparam int LEN_W     = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
  localparam logic [CHAR_W-1:0] END_CHAR   = 8'h00;
  localparam logic [LEN_W-1:0]  LEN_RESET  = 4'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELIM_BYTES = 1'b0,
    REG_DELIM_LEN   = 1'b1
  } cfg_reg_t;

  // input register contents
  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] ch;
  } stage_t;

  // one result word headed for the output register
  typedef struct packed {
    logic             valid;
    logic [OUT_W-1:0] start;
    logic [OUT_W-1:0] length;
    logic             last;
  } res_t;

endpackage

`default_nettype wire

[rtl/sdt_in_stage.sv]
`default_nettype none

module sdt_in_stage (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic [sdt_pkg::CHAR_W-1:0] in_char_in,
  input  wire logic                      advance,
  output logic                           in_stall,
  output sdt_pkg::stage_t                s1
);

  logic                       valid_r, valid_nxt;
  logic [sdt_pkg::CHAR_W-1:0] ch_r, ch_nxt;
  logic                       in_fire;

  // stall only when holding a word the core cannot take this cycle
  assign in_stall  = valid_r && !advance;
  assign in_fire   = in_valid && !in_stall;
  assign valid_nxt = in_fire || (valid_r && !advance);
  assign ch_nxt    = in_fire ? in_char_in : ch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r <= ch_nxt;
  end

  assign s1.valid = valid_r;
  assign s1.ch    = ch_r;

endmodule

`default_nettype wire

[rtl/sdt_core.sv]
`default_nettype none

module sdt_core #(
  parameter int MAX_DELIM = sdt_pkg::MAX_DELIM_DEF,
  parameter int POS_BITS  = sdt_pkg::POS_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [sdt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sdt_pkg::DELIM_W-1:0]   cfg_wdata,
  input  wire sdt_pkg::stage_t               s1,
  input  wire logic                          advance,
  output sdt_pkg::res_t                      res
);

  localparam int WIN_W  = MAX_DELIM * sdt_pkg::CHAR_W;
  localparam int FILL_W = $clog2(MAX_DELIM + 1);
  localparam int PW     = POS_BITS + 1;
  localparam int LW     = sdt_pkg::LEN_W;
  localparam int CW     = sdt_pkg::CHAR_W;

  localparam logic [POS_BITS-1:0] POS_MAX  = {POS_BITS{1'b1}};
  localparam logic [LW-1:0]       LEN_CAP  = LW'(MAX_DELIM);
  localparam logic [FILL_W-1:0]   FILL_CAP = FILL_W'(MAX_DELIM);

  // configuration
  logic [WIN_W-1:0] delim_r, delim_nxt;
  logic [LW-1:0]    dlen_r, dlen_nxt;

  // segment state
  logic [WIN_W-1:0]    win_r, win_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [POS_BITS-1:0] fnp_r, fnp_nxt;
  logic                seen_r, seen_nxt;

  logic                fire, is_end, non_space, matched, match_sel;
  logic [LW-1:0]       n_eff;
  logic [WIN_W-1:0]    win_sh;
  logic [FILL_W-1:0]   fill_inc;
  logic [POS_BITS-1:0] pos_inc, fnp_upd, tok_end, end_sel, fnp_sel, start, tlen;
  logic                seen_upd, seen_sel;
  logic [PW-1:0]       end_wide;
  logic [MAX_DELIM:1]  hit;
  logic                eq [MAX_DELIM][MAX_DELIM];

  // config write port
  always_comb begin
    delim_nxt = delim_r;
    dlen_nxt  = dlen_r;
    if (cfg_we) begin
      unique case (sdt_pkg::cfg_reg_t'(cfg_index))
        sdt_pkg::REG_DELIM_BYTES: delim_nxt = cfg_wdata[WIN_W-1:0];
        sdt_pkg::REG_DELIM_LEN:   dlen_nxt  = cfg_wdata[LW-1:0];
        default:                  delim_nxt = delim_r;
      endcase
    end
  end

  assign fire      = s1.valid && advance;
  assign is_end    = (s1.ch == sdt_pkg::END_CHAR);
  assign non_space = (s1.ch != sdt_pkg::SPACE_CHAR);
  assign n_eff     = (dlen_r > LEN_CAP) ? LEN_CAP : dlen_r;

  assign win_sh   = (win_r << CW) | WIN_W'(s1.ch);
  assign fill_inc = (fill_r == FILL_CAP) ? fill_r : fill_r + FILL_W'(1);
  assign pos_inc  = (pos_r == POS_MAX) ? pos_r : pos_r + POS_BITS'(1);
  assign seen_upd = seen_r || non_space;
  assign fnp_upd  = (!seen_r && non_space) ? pos_r : fnp_r;

  // window byte k (k = 0 newest) against delimiter byte j
  always_comb begin
    for (int k = 0; k < MAX_DELIM; k++) begin
      for (int j = 0; j < MAX_DELIM; j++) begin
        eq[k][j] = (win_sh[k*CW +: CW] == delim_r[j*CW +: CW]);
      end
    end
  end

  // per delimiter length: newest m bytes read oldest-first equal the delimiter
  always_comb begin
    for (int m = 1; m <= MAX_DELIM; m++) begin
      hit[m] = 1'b1;
      for (int j = 0; j < MAX_DELIM; j++) begin
        if (j < m && !eq[m-1-j][j]) begin
          hit[m] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    match_sel = 1'b0;
    for (int m = 1; m <= MAX_DELIM; m++) begin
      if (n_eff == LW'(m)) begin
        match_sel = hit[m];
      end
    end
  end

  assign matched = !is_end && (n_eff != '0) && (LW'(fill_inc) >= n_eff) && match_sel;

  assign end_wide = {1'b0, pos_r} + PW'(1) - PW'(n_eff);
  assign tok_end  = end_wide[POS_BITS-1:0];

  // the end byte reports from current state, a delimiter from updated state
  assign end_sel  = is_end ? pos_r  : tok_end;
  assign seen_sel = is_end ? seen_r : seen_upd;
  assign fnp_sel  = is_end ? fnp_r  : fnp_upd;
  assign start    = (seen_sel && fnp_sel < end_sel) ? fnp_sel : end_sel;
  assign tlen     = end_sel - start;

  assign res.valid  = fire && (is_end || matched);
  assign res.start  = sdt_pkg::OUT_W'(start);
  assign res.length = sdt_pkg::OUT_W'(tlen);
  assign res.last   = is_end;

  always_comb begin
    win_nxt  = win_r;
    pos_nxt  = pos_r;
    fill_nxt = fill_r;
    fnp_nxt  = fnp_r;
    seen_nxt = seen_r;
    if (fire) begin
      priority if (is_end) begin
        win_nxt  = '0;
        pos_nxt  = '0;
        fill_nxt = '0;
        fnp_nxt  = '0;
        seen_nxt = 1'b0;
      end else if (matched) begin
        win_nxt  = '0;
        pos_nxt  = pos_inc;
        fill_nxt = '0;
        fnp_nxt  = '0;
        seen_nxt = 1'b0;
      end else begin
        win_nxt  = win_sh;
        pos_nxt  = pos_inc;
        fill_nxt = fill_inc;
        fnp_nxt  = fnp_upd;
        seen_nxt = seen_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= '0;
      dlen_r  <= sdt_pkg::LEN_RESET;
      win_r   <= '0;
      pos_r   <= '0;
      fill_r  <= '0;
      fnp_r   <= '0;
      seen_r  <= 1'b0;
    end else begin
      delim_r <= delim_nxt;
      dlen_r  <= dlen_nxt;
      win_r   <= win_nxt;
      pos_r   <= pos_nxt;
      fill_r  <= fill_nxt;
      fnp_r   <= fnp_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/sdt_out_stage.sv]
`default_nettype none

module sdt_out_stage (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire sdt_pkg::res_t              res,
  input  wire logic                       out_stall,
  output logic                            advance,
  output logic                            out_valid,
  output logic [sdt_pkg::OUT_W-1:0]       out_token_start,
  output logic [sdt_pkg::OUT_W-1:0]       out_token_length,
  output logic                            out_last
);

  logic                      valid_r, valid_nxt;
  logic [sdt_pkg::OUT_W-1:0] start_r, start_nxt;
  logic [sdt_pkg::OUT_W-1:0] len_r, len_nxt;
  logic                      last_r, last_nxt;
  logic                      load;

  // core may step whenever this register is empty or being drained
  assign advance   = !valid_r || !out_stall;
  assign load      = advance && res.valid;
  assign valid_nxt = advance ? res.valid : valid_r;
  assign start_nxt = load ? res.start  : start_r;
  assign len_nxt   = load ? res.length : len_r;
  assign last_nxt  = load ? res.last   : last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    len_r   <= len_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid        = valid_r;
  assign out_token_start  = start_r;
  assign out_token_length = len_r;
  assign out_last         = last_r;

endmodule

`default_nettype wire

[rtl/string_delimiter_tokenizer.sv]
// Splits a zero-terminated byte string on a configurable delimiter of up to
// MAX_DELIM bytes and returns one word per token: offset of its first
// non-space byte, its length, and a last flag on the token closed by the
// zero byte. One byte is taken per cycle while in_stall is low; each byte
// passes the input register, then its result goes to the result register.
// Input stalls only while both the input and result registers hold words
// and the result side is stalled. Write the delimiter registers only when
// no string is in flight.
`default_nettype none

module string_delimiter_tokenizer #(
  parameter int MAX_DELIM = sdt_pkg::MAX_DELIM_DEF,
  parameter int POS_BITS  = sdt_pkg::POS_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [sdt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sdt_pkg::DELIM_W-1:0]   cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [sdt_pkg::CHAR_W-1:0]    in_char_in,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [sdt_pkg::OUT_W-1:0]          out_token_start,
  output logic [sdt_pkg::OUT_W-1:0]          out_token_length,
  output logic                               out_last
);

  sdt_pkg::stage_t s1;
  sdt_pkg::res_t   res;
  logic            advance;

  sdt_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_char_in (in_char_in),
    .advance    (advance),
    .in_stall   (in_stall),
    .s1         (s1)
  );

  sdt_core #(
    .MAX_DELIM (MAX_DELIM),
    .POS_BITS  (POS_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s1        (s1),
    .advance   (advance),
    .res       (res)
  );

  sdt_out_stage u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .res              (res),
    .out_stall        (out_stall),
    .advance          (advance),
    .out_valid        (out_valid),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

[rtl/sdt_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module sdt_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [sdt_pkg::OUT_W-1:0]  out_token_start,
  input wire logic [sdt_pkg::OUT_W-1:0]  out_token_length,
  input wire logic                       out_last
);

  `SDT_ASSERT_ON(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_token_start) && $stable(out_token_length) && $stable(out_last), "stalled result word changed")
  `SDT_ASSERT_ALL(a_reset_idle, clk, !rst_n |=> !out_valid && !in_stall, "not idle after reset")
  `SDT_ASSERT_ON(a_stall_cause, clk, rst_n, in_stall |-> out_valid && out_stall, "input stalled with result side free")
  `SDT_ASSERT_ON(a_in_hold, clk, rst_n, in_valid && in_stall |=> in_valid, "stalled input word dropped")

endmodule

bind string_delimiter_tokenizer sdt_checker u_sdt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_token_start  (out_token_start),
  .out_token_length (out_token_length),
  .out_last         (out_last)
);

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 100ps

module tb;

  typedef struct packed {
    logic [sdt_pkg::OUT_W-1:0] start;
    logic [sdt_pkg::OUT_W-1:0] length;
    logic                      lst;
  } token_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                        cfg_we = 1'b0;
  sdt_pkg::cfg_reg_t           cfg_index = sdt_pkg::REG_DELIM_BYTES;
  logic [sdt_pkg::DELIM_W-1:0] cfg_wdata = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [sdt_pkg::CHAR_W-1:0]  in_char_in = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [sdt_pkg::OUT_W-1:0]   out_token_start;
  logic [sdt_pkg::OUT_W-1:0]   out_token_length;
  logic                        out_last;

  string_delimiter_tokenizer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_in       (in_char_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_last         (out_last)
  );

  always #5 clk = ~clk;

  // tokenizer shadow state and register copies
  logic [sdt_pkg::DELIM_W-1:0] delim = '0;
  logic [sdt_pkg::LEN_W-1:0]   delim_len = sdt_pkg::LEN_RESET;
  logic [63:0]                 window = '0;
  logic [15:0]                 pos = '0;
  logic [3:0]                  fill = '0;
  logic [15:0]                 nonspace_pos = '0;
  logic                        seen_nonspace = 1'b0;

  logic [sdt_pkg::CHAR_W-1:0] byte_q[$];
  token_t                     token_q[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int offered_cnt = 0;
  int taken_cnt = 0;
  int hold_reqs = 0;
  int holds_started = 0;
  int hold_cnt = 0;
  int err_cnt = 0;
  int n_tokens = 0;
  int n_bytes = 0;
  int n_strings = 0;
  int n_writes = 0;

  function automatic token_t make_token(input logic [15:0] tend, input logic lst);
    token_t t;
    t.start = tend;
    if (seen_nonspace && nonspace_pos < tend) t.start = nonspace_pos;
    t.length = tend - t.start;
    t.lst = lst;
    return t;
  endfunction

  function automatic void clear_segment();
    window = '0;
    fill = '0;
    nonspace_pos = '0;
    seen_nonspace = 1'b0;
  endfunction

  function automatic void tokenize_byte(input logic [sdt_pkg::CHAR_W-1:0] c);
    logic [15:0] p;
    int n;
    logic hit;
    p = pos;
    if (c == sdt_pkg::END_CHAR) begin
      token_q.push_back(make_token(p, 1'b1));
      clear_segment();
      pos = '0;
    end else begin
      window = {window[55:0], c};
      if (fill < sdt_pkg::MAX_DELIM_DEF) fill = fill + 4'd1;
      if (c != sdt_pkg::SPACE_CHAR && !seen_nonspace) begin
        seen_nonspace = 1'b1;
        nonspace_pos = p;
      end
      pos = (p == 16'hFFFF) ? p : p + 16'd1;
      n = (delim_len > sdt_pkg::MAX_DELIM_DEF) ? sdt_pkg::MAX_DELIM_DEF : delim_len;
      hit = (n != 0) && (fill >= n);
      for (int j = 0; j < n; j++) begin
        if (window[8*(n-1-j) +: 8] != delim[8*j +: 8]) hit = 1'b0;
      end
      if (hit) begin
        token_q.push_back(make_token(p + 16'd1 - 16'(n), 1'b0));
        clear_segment();
      end
    end
  endfunction

  // driver: new word at the falling edge once the previous one was taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && taken_cnt != offered_cnt) begin
    end else if (byte_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
      in_valid <= 1'b1;
      in_char_in <= byte_q.pop_front();
      offered_cnt <= offered_cnt + 1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result side stall, with long holds on request
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_reqs != holds_started) begin
      out_stall <= 1'b1;
      hold_cnt <= 150;
      holds_started <= holds_started + 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    token_t exp_tok;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (token_q.size() == 0) begin
          $display("%0t: unexpected word start=%0d length=%0d last=%0b", $time,
                   out_token_start, out_token_length, out_last);
          err_cnt++;
        end else begin
          exp_tok = token_q.pop_front();
          n_tokens++;
          if (out_token_start !== exp_tok.start) begin
            $display("%0t: token_start expected %0d actual %0d", $time,
                     exp_tok.start, out_token_start);
            err_cnt++;
          end
          if (out_token_length !== exp_tok.length) begin
            $display("%0t: token_length expected %0d actual %0d", $time,
                     exp_tok.length, out_token_length);
            err_cnt++;
          end
          if (out_last !== exp_tok.lst) begin
            $display("%0t: last expected %0b actual %0b", $time, exp_tok.lst, out_last);
            err_cnt++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        tokenize_byte(in_char_in);
        taken_cnt <= taken_cnt + 1;
      end
    end
  end

  task automatic push_byte(input logic [sdt_pkg::CHAR_W-1:0] b);
    byte_q.push_back(b);
    n_bytes++;
  endtask

  task automatic wait_idle();
    while (!(byte_q.size() == 0 && taken_cnt == offered_cnt && token_q.size() == 0))
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input sdt_pkg::cfg_reg_t idx,
                           input logic [sdt_pkg::DELIM_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    if (idx == sdt_pkg::REG_DELIM_BYTES) delim = v;
    else delim_len = v[sdt_pkg::LEN_W-1:0];
    n_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [sdt_pkg::CHAR_W-1:0] pick_char();
    case ($urandom_range(5))
      0: return sdt_pkg::SPACE_CHAR;
      1: return "a";
      2: return "b";
      3: return ",";
      4: return ":";
      default: return sdt_pkg::CHAR_W'($urandom_range(255));
    endcase
  endfunction

  task automatic random_config();
    logic [sdt_pkg::DELIM_W-1:0] d;
    logic [sdt_pkg::DELIM_W-1:0] lw;
    int r;
    if ($urandom_range(3) == 0) begin
      d = {$urandom, $urandom};
    end else begin
      for (int i = 0; i < 8; i++) d[8*i +: 8] = pick_char();
    end
    lw = {$urandom, $urandom};
    r = $urandom_range(7);
    case (r)
      0: lw[3:0] = 4'd0;
      1: lw[3:0] = 4'd1;
      2: lw[3:0] = 4'd2;
      3: lw[3:0] = 4'd3;
      4: lw[3:0] = 4'd8;
      5: lw[3:0] = 4'($urandom_range(15, 9));
      default: lw[3:0] = 4'($urandom_range(8, 1));
    endcase
    if ($urandom_range(1)) begin
      write_reg(sdt_pkg::REG_DELIM_BYTES, d);
      write_reg(sdt_pkg::REG_DELIM_LEN, lw);
    end else begin
      write_reg(sdt_pkg::REG_DELIM_LEN, lw);
      write_reg(sdt_pkg::REG_DELIM_BYTES, d);
    end
  endtask

  // mix of whole delimiters, broken prefixes, spaces and noise
  task automatic push_string(input int maxlen);
    int len;
    int k;
    int n;
    int kind;
    logic [sdt_pkg::CHAR_W-1:0] b;
    len = $urandom_range(maxlen);
    n = (delim_len > sdt_pkg::MAX_DELIM_DEF) ? sdt_pkg::MAX_DELIM_DEF : delim_len;
    k = 0;
    while (k < len) begin
      kind = $urandom_range(9);
      if (kind < 3 && n > 0) begin
        for (int j = 0; j < n; j++) begin
          b = delim[8*j +: 8];
          if (b != sdt_pkg::END_CHAR) push_byte(b);
        end
        k += n;
      end else if (kind == 3 && n > 1) begin
        for (int j = 0; j < $urandom_range(n - 1, 1); j++) begin
          b = delim[8*j +: 8];
          if (b != sdt_pkg::END_CHAR) push_byte(b);
        end
        k++;
      end else if (kind < 6) begin
        push_byte(sdt_pkg::SPACE_CHAR);
        k++;
      end else if (kind < 9) begin
        b = (n > 0 && $urandom_range(1)) ? delim[8*$urandom_range(n - 1) +: 8] : pick_char();
        push_byte((b == sdt_pkg::END_CHAR) ? 8'h61 : b);
        k++;
      end else begin
        push_byte(sdt_pkg::CHAR_W'($urandom_range(255, 1)));
        k++;
      end
    end
    push_byte(sdt_pkg::END_CHAR);
    n_strings++;
  endtask

  initial begin
    int start_bytes;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    tx_idle_pct = 14;
    rx_idle_pct = 63;

    // reset delimiter holds a zero byte, so nothing splits
    push_byte("a"); push_byte(sdt_pkg::SPACE_CHAR); push_byte(8'hFF); push_byte(8'h01);
    push_byte(8'h20); push_byte(sdt_pkg::END_CHAR);
    n_strings++;
    wait_idle();

    write_reg(sdt_pkg::REG_DELIM_BYTES, 64'h2C);
    write_reg(sdt_pkg::REG_DELIM_LEN, 64'd1);
    push_byte(sdt_pkg::SPACE_CHAR); push_byte(sdt_pkg::SPACE_CHAR); push_byte(",");
    push_byte("x"); push_byte(","); push_byte(","); push_byte(sdt_pkg::END_CHAR);
    n_strings++;
    wait_idle();

    // length 15 is clamped to eight
    write_reg(sdt_pkg::REG_DELIM_BYTES, '1);
    write_reg(sdt_pkg::REG_DELIM_LEN, '1);
    repeat (8) push_byte(8'hFF);
    push_byte(sdt_pkg::SPACE_CHAR); push_byte(sdt_pkg::END_CHAR);
    n_strings++;
    wait_idle();

    for (int mode = 0; mode < 3; mode++) begin
      tx_idle_pct = (mode == 0) ? 14 : (mode == 1) ? 63 : 0;
      rx_idle_pct = (mode == 0) ? 63 : (mode == 1) ? 14 : 0;
      for (int ph = 0; ph < 5; ph++) begin
        random_config();
        if (mode == 0 && ph == 0) write_reg(sdt_pkg::REG_DELIM_LEN, 64'd0);
        start_bytes = n_bytes;
        while (n_bytes - start_bytes < 50) push_string(30);
        if (mode == 1 && ph == 2) wait_idle();
        while (n_bytes - start_bytes < 100) push_string(30);
        if (mode == 0 && ph == 1) hold_reqs++;
        wait_idle();
      end
    end

    $display("Run covered %0d bytes in %0d strings, %0d tokens checked, %0d register writes,",
             n_bytes, n_strings, n_tokens, n_writes);
    $display("three idle mixes, a long result hold and a full drain mid-string stream.");
    if (err_cnt == 0 && token_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #15000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/sdt_pkg.sv
rtl/sdt_in_stage.sv
rtl/sdt_core.sv
rtl/sdt_out_stage.sv
rtl/string_delimiter_tokenizer.sv
rtl/sdt_checker.sv
bench/tb.sv
